>>> hdl/sck_pkg.sv
package sck_pkg;

  // fixed-point format of |t|, d, terms and the running sum
  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = 40;
  localparam int Q_W       = 48;
  localparam int D_W       = 42;
  localparam int MUL_W     = 32;
  localparam int DVD_W     = 64;
  localparam int DVS_W     = 32;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] EXP_LIMIT = SUM_W'(12) << FRAC_BITS;

  localparam logic [31:0] S3_Q30    = 32'd1859775393;
  localparam logic [31:0] S5_Q30    = 32'd2400959709;
  localparam logic [31:0] L2_Q30    = 32'd744261118;
  localparam logic [31:0] LOG2E_Q28 = 32'd387270501;

  // ceil(2^33 / 3), exact floor(x / 3) for any 32-bit x after a 33-bit shift
  localparam logic [31:0] RECIP3_Q33 = 32'hAAAA_AAAB;

  // Q1.30 to Q1.16 output shift, exp series length, largest useful exponent
  localparam int OUT_SHIFT    = 14;
  localparam int TAYLOR_TERMS = 12;
  localparam int EXP_N_MAX    = 17;
  localparam int LN_ITERS     = 30;

  localparam logic [2:0] KIND_GAUSS = 3'd0;
  localparam logic [2:0] KIND_EXP   = 3'd1;
  localparam logic [2:0] KIND_M32   = 3'd2;
  localparam logic [2:0] KIND_M52   = 3'd3;
  localparam logic [2:0] KIND_WHITE = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV,
    ST_KIND,
    ST_GAUSS,
    ST_D_HI,
    ST_D_LO,
    ST_D_SUM,
    ST_M_SETUP,
    ST_SQ,
    ST_SQW,
    ST_LN_NORM,
    ST_LN_SQ,
    ST_LN_UPD,
    ST_LN_IP,
    ST_LN_FR,
    ST_LN_RES,
    ST_MTERM,
    ST_ADD,
    ST_FIN,
    ST_EX_U,
    ST_EX_G,
    ST_EX_G2,
    ST_EX_TM,
    ST_EX_TD,
    ST_EX_TW,
    ST_EX_OUT,
    ST_PUSH
  } sck_state_t;

endpackage

>>> hdl/sck_div.sv
module sck_div import sck_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      rem_nxt = fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> hdl/separable_covariance_kernel_unit.sv
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall   in_coord_diff, in_length_scale, in_last_coord
// out_     output     out_valid / out_stall out_covariance, out_sum_saturated
// cfg_     input      cfg_write_en          cfg_kernel_kind
//
// a transaction for gauss, exp and whitenoise is bound by the 64-bit bit-serial
// divider that forms |t|; matern 3/2 adds a leading-one search and up to 30
// squarings on the shared multiplier, and matern 5/2 adds two more multiplies
// for d*d/3 by reciprocal; the transaction that closes a vector runs the exp
// series with a reciprocal multiply for each index, but not for whitenoise or
// for a sum that has reached the exp limit
// rst_n is synchronous: sum, flag, kernel kind and output valid clear at once
// a finished result sits in the output register; the next input transaction is
// taken while it waits, and the sequencer only holds when a second result is ready
module separable_covariance_kernel_unit import sck_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_coord_diff,
  input  logic        [31:0] in_length_scale,
  input  logic               in_last_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [16:0] out_covariance,
  output logic               out_sum_saturated,
  input  logic               cfg_write_en,
  input  logic         [2:0] cfg_kernel_kind
);

  sck_state_t state_r, state_nxt;

  // architectural state
  logic [2:0]       kind_r, kind_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             sat_r, sat_nxt;

  // per-transaction working registers
  logic              last_r, last_nxt;
  logic              magnz_r, magnz_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [63:0]       prod_r;
  logic [63:0]       acc_r, acc_nxt;
  logic [D_W-1:0]    d_r, d_nxt;
  logic [3:0]        s_r, s_nxt;
  logic [30:0]       q3_r, q3_nxt;
  logic [1:0]        r3_r, r3_nxt;
  logic [63:0]       m_r, m_nxt;
  logic signed [7:0] em_r, em_nxt;
  logic [5:0]        p_r, p_nxt;
  logic [5:0]        ip_r, ip_nxt;
  logic [30:0]       y_r, y_nxt;
  logic [29:0]       fr_r, fr_nxt;
  logic [4:0]        it_r, it_nxt;
  logic [D_W-1:0]    ln_r, ln_nxt;
  logic [Q_W-1:0]    term_r, term_nxt;
  logic [4:0]        n_r, n_nxt;
  logic [29:0]       g_r, g_nxt;
  logic [30:0]       t_r, t_nxt;
  logic [30:0]       e_r, e_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [16:0]       cov_r, cov_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [16:0] out_cov_r, out_cov_nxt;
  logic        out_sat_r, out_sat_nxt;

  // shared multiplier and divider
  logic [MUL_W-1:0] mul_a, mul_b;
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  // helpers
  logic [31:0]       diff_u, in_mag;
  logic              in_acc;
  logic              slot_free;
  logic              kind_sat;
  logic [31:0]       mat_const;
  logic [71:0]       d_full;
  logic [3:0]        s_sel;
  logic [D_W:0]      lin_base;
  logic [63:0]       lin;
  logic [31:0]       ds_w;
  logic [30:0]       q3_w;
  logic [31:0]       r3_full;
  logic [32:0]       two_ar;
  logic [63:0]       sq_w;
  logic signed [7:0] ip_s;
  logic [31:0]       yy;
  logic [36:0]       ln_sum;
  logic [SUM_W+8:0]  add_full;
  logic [34:0]       u_w;
  logic [5:0]        out_sh;
  logic [31:0]       rnd;
  logic [31:0]       rk_mul;
  logic [5:0]        rk_sh;
  logic [30:0]       quo_k;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign diff_u = $unsigned(in_coord_diff);
  assign in_mag = diff_u[31] ? (~diff_u + 32'd1) : diff_u;

  // ratio too large for the selected kind
  assign kind_sat = ((kind_r <= KIND_WHITE) && (q_r[Q_W-1:SUM_W] != '0)) ||
                    ((kind_r == KIND_GAUSS) && (q_r[Q_W-1:32] != '0));

  assign mat_const = (kind_r == KIND_M52) ? S5_Q30 : S3_Q30;

  // d = floor(q * c / 2^30) from two 20-bit partial products
  assign d_full = {acc_r[51:0], 20'd0} + {20'd0, prod_r[51:0]};

  // smallest shift that brings d under 2^32
  always_comb begin
    s_sel = '0;
    for (int i = 1; i <= D_W - 32; i++) begin
      if (d_r[31+i]) s_sel = 4'(i);
    end
  end

  assign lin_base = ((D_W+1)'(1) << FRAC_BITS) + (D_W+1)'(d_r);
  assign lin      = 64'(lin_base >> s_r) << (5'(FRAC_BITS) - 5'(s_r));

  // ds = 3a + r, so floor(ds^2 / 3) = 3a^2 + 2ar + (r == 2)
  assign ds_w    = 32'(d_r >> s_r);
  assign q3_w    = prod_r[63:33];
  assign r3_full = ds_w - {q3_w, 1'b0} - {1'b0, q3_w};
  assign two_ar  = (r3_r == 2'd2) ? {q3_r, 2'b00} :
                   (r3_r == 2'd1) ? {1'b0, q3_r, 1'b0} : '0;
  assign sq_w    = {prod_r[62:0], 1'b0} + prod_r + 64'(two_ar) + 64'(r3_r == 2'd2);

  assign ip_s   = $signed({2'b00, p_r}) + em_r;
  assign yy     = prod_r[61:30];
  assign ln_sum = 37'(acc_r[35:0]) + 37'(prod_r[59:30]);

  assign add_full = (SUM_W+9)'(sum_r) + (SUM_W+9)'(term_r);

  assign u_w    = prod_r[FRAC_BITS-2 +: 35];
  assign out_sh = 6'(OUT_SHIFT) + 6'(n_r);
  assign rnd    = 32'(e_r) + (32'd1 << (out_sh - 6'd1));

  // reciprocal of the series index: ceil(2^sh / k), exact for 31-bit terms
  always_comb begin
    case (k_r)
      4'd2:    begin rk_mul = 32'h8000_0000; rk_sh = 6'd32; end
      4'd3:    begin rk_mul = 32'hAAAA_AAAB; rk_sh = 6'd33; end
      4'd4:    begin rk_mul = 32'h8000_0000; rk_sh = 6'd33; end
      4'd5:    begin rk_mul = 32'hCCCC_CCCD; rk_sh = 6'd34; end
      4'd6:    begin rk_mul = 32'hAAAA_AAAB; rk_sh = 6'd34; end
      4'd7:    begin rk_mul = 32'h9249_2493; rk_sh = 6'd34; end
      4'd8:    begin rk_mul = 32'h8000_0000; rk_sh = 6'd34; end
      4'd9:    begin rk_mul = 32'hE38E_38E4; rk_sh = 6'd35; end
      4'd10:   begin rk_mul = 32'hCCCC_CCCD; rk_sh = 6'd35; end
      4'd11:   begin rk_mul = 32'hBA2E_8BA3; rk_sh = 6'd35; end
      4'd12:   begin rk_mul = 32'hAAAA_AAAB; rk_sh = 6'd35; end
      // index one divides by one
      default: begin rk_mul = 32'h8000_0000; rk_sh = 6'd31; end
    endcase
  end

  assign quo_k = 31'(prod_r >> rk_sh);

  sck_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ((in_mag != '0) && (in_length_scale != '0)) ? ST_DIV : ST_KIND;
        end
      end
      ST_DIV:     if (div_done) state_nxt = ST_KIND;
      ST_KIND: begin
        if (kind_sat) begin
          state_nxt = ST_FIN;
        end else begin
          case (kind_r)
            KIND_GAUSS:         state_nxt = ST_GAUSS;
            KIND_EXP:           state_nxt = ST_ADD;
            KIND_WHITE:         state_nxt = ST_ADD;
            KIND_M32, KIND_M52: state_nxt = ST_D_HI;
            default:            state_nxt = ST_FIN;
          endcase
        end
      end
      ST_GAUSS:   state_nxt = ST_ADD;
      ST_D_HI:    state_nxt = ST_D_LO;
      ST_D_LO:    state_nxt = ST_D_SUM;
      ST_D_SUM:   state_nxt = ST_M_SETUP;
      ST_M_SETUP: state_nxt = (kind_r == KIND_M52) ? ST_SQ : ST_LN_NORM;
      ST_SQ:      state_nxt = ST_SQW;
      ST_SQW:     state_nxt = ST_LN_NORM;
      ST_LN_NORM: begin
        if (m_r == '0) begin
          state_nxt = ST_MTERM;
        end else if (m_r[63]) begin
          state_nxt = (ip_s < 0) ? ST_MTERM : ST_LN_SQ;
        end
      end
      ST_LN_SQ:   state_nxt = ST_LN_UPD;
      ST_LN_UPD:  state_nxt = (it_r == 5'(LN_ITERS-1)) ? ST_LN_IP : ST_LN_SQ;
      ST_LN_IP:   state_nxt = ST_LN_FR;
      ST_LN_FR:   state_nxt = ST_LN_RES;
      ST_LN_RES:  state_nxt = ST_MTERM;
      ST_MTERM:   state_nxt = ST_ADD;
      ST_ADD:     state_nxt = ST_FIN;
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if ((kind_r == KIND_WHITE) || (sum_r >= EXP_LIMIT)) begin
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_EX_U;
        end
      end
      ST_EX_U:    state_nxt = ST_EX_G;
      ST_EX_G:    state_nxt = ST_EX_G2;
      ST_EX_G2:   state_nxt = ST_EX_TM;
      ST_EX_TM:   state_nxt = ST_EX_TD;
      ST_EX_TD:   state_nxt = ST_EX_TW;
      ST_EX_TW:   state_nxt = (k_r == 4'(TAYLOR_TERMS)) ? ST_EX_OUT : ST_EX_TM;
      ST_EX_OUT:  state_nxt = ST_PUSH;
      ST_PUSH:    if (slot_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and unit controls
  always_comb begin
    kind_nxt  = cfg_write_en ? cfg_kernel_kind : kind_r;
    sum_nxt   = sum_r;
    sat_nxt   = sat_r;
    last_nxt  = last_r;
    magnz_nxt = magnz_r;
    q_nxt     = q_r;
    acc_nxt   = acc_r;
    d_nxt     = d_r;
    s_nxt     = s_r;
    q3_nxt    = q3_r;
    r3_nxt    = r3_r;
    m_nxt     = m_r;
    em_nxt    = em_r;
    p_nxt     = p_r;
    ip_nxt    = ip_r;
    y_nxt     = y_r;
    fr_nxt    = fr_r;
    it_nxt    = it_r;
    ln_nxt    = ln_r;
    term_nxt  = term_r;
    n_nxt     = n_r;
    g_nxt     = g_r;
    t_nxt     = t_r;
    e_nxt     = e_r;
    k_nxt     = k_r;
    cov_nxt   = cov_r;
    out_cov_nxt = out_cov_r;
    out_sat_nxt = out_sat_r;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          last_nxt  = in_last_coord;
          magnz_nxt = (in_mag != '0);
          if (in_mag == '0) begin
            q_nxt = '0;
          end else if (in_length_scale == '0) begin
            q_nxt = Q_W'(SUM_MAX) + Q_W'(1);
          end else begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(in_mag) << FRAC_BITS;
            div_dvs   = in_length_scale;
          end
        end
      end
      ST_DIV: begin
        if (div_done) q_nxt = div_quo[Q_W-1:0];
      end
      ST_KIND: begin
        if (kind_sat) begin
          sum_nxt = SUM_MAX;
          sat_nxt = 1'b1;
        end else begin
          case (kind_r)
            KIND_GAUSS: begin
              mul_a = q_r[31:0];
              mul_b = q_r[31:0];
            end
            KIND_EXP:   term_nxt = q_r;
            // a nonzero difference that truncates to zero still counts
            KIND_WHITE: term_nxt = (magnz_r && (q_r == '0)) ? Q_W'(1) : q_r;
            default: ;
          endcase
        end
      end
      ST_GAUSS:   term_nxt = Q_W'(prod_r >> (FRAC_BITS + 1));
      ST_D_HI: begin
        mul_a = 32'(q_r[39:20]);
        mul_b = mat_const;
      end
      ST_D_LO: begin
        acc_nxt = prod_r;
        mul_a   = 32'(q_r[19:0]);
        mul_b   = mat_const;
      end
      ST_D_SUM:   d_nxt = D_W'(d_full >> 30);
      ST_M_SETUP: begin
        p_nxt = 6'd63;
        if (kind_r == KIND_M52) begin
          s_nxt = s_sel;
          mul_a = 32'(d_r >> s_sel);
          mul_b = RECIP3_Q33;
        end else begin
          m_nxt  = 64'(d_r) + (64'd1 << FRAC_BITS);
          em_nxt = 8'(-FRAC_BITS);
        end
      end
      // a = ds / 3 from the reciprocal product, then a^2
      ST_SQ: begin
        q3_nxt = q3_w;
        r3_nxt = r3_full[1:0];
        mul_a  = 32'(q3_w);
        mul_b  = 32'(q3_w);
      end
      ST_SQW: begin
        m_nxt  = sq_w + lin;
        em_nxt = 8'({s_r, 1'b0}) - 8'(2 * FRAC_BITS);
      end
      // leading-one search, one bit a cycle
      ST_LN_NORM: begin
        if (m_r == '0) begin
          ln_nxt = '0;
        end else if (m_r[63]) begin
          y_nxt  = m_r[63:33];
          fr_nxt = '0;
          it_nxt = '0;
          ip_nxt = ip_s[5:0];
          ln_nxt = '0;
        end else begin
          m_nxt = m_r << 1;
          p_nxt = p_r - 6'd1;
        end
      end
      ST_LN_SQ: begin
        mul_a = 32'(y_r);
        mul_b = 32'(y_r);
      end
      // one fraction bit of log2 per squaring
      ST_LN_UPD: begin
        fr_nxt = {fr_r[28:0], yy[31]};
        y_nxt  = yy[31] ? yy[31:1] : yy[30:0];
        it_nxt = it_r + 5'd1;
      end
      ST_LN_IP: begin
        mul_a = 32'(ip_r);
        mul_b = L2_Q30;
      end
      ST_LN_FR: begin
        acc_nxt = prod_r;
        mul_a   = 32'(fr_r);
        mul_b   = L2_Q30;
      end
      ST_LN_RES:  ln_nxt = D_W'(ln_sum >> (30 - FRAC_BITS));
      ST_MTERM:   term_nxt = (d_r > ln_r) ? Q_W'(d_r - ln_r) : '0;
      // saturating accumulate
      ST_ADD: begin
        if (add_full > (SUM_W+9)'(SUM_MAX)) begin
          sum_nxt = SUM_MAX;
          sat_nxt = 1'b1;
        end else begin
          sum_nxt = add_full[SUM_W-1:0];
        end
      end
      ST_FIN: begin
        if (last_r) begin
          if (kind_r == KIND_WHITE) begin
            cov_nxt = ((sum_r == '0) && !sat_r) ? 17'd65536 : 17'd0;
          end else if (sum_r >= EXP_LIMIT) begin
            cov_nxt = '0;
          end
        end
      end
      ST_EX_U: begin
        mul_a = 32'(sum_r[FRAC_BITS+3:0]);
        mul_b = LOG2E_Q28;
      end
      // u = s * log2(e): integer part n, fraction back to natural log
      ST_EX_G: begin
        n_nxt = u_w[34:30];
        mul_a = 32'(u_w[29:0]);
        mul_b = L2_Q30;
      end
      ST_EX_G2: begin
        g_nxt = prod_r[59:30];
        t_nxt = 31'd1 << 30;
        e_nxt = 31'd1 << 30;
        k_nxt = 4'd1;
      end
      ST_EX_TM: begin
        mul_a = 32'(t_r);
        mul_b = 32'(g_r);
      end
      ST_EX_TD: begin
        mul_a = 32'(prod_r[60:30]);
        mul_b = rk_mul;
      end
      // alternating series terms
      ST_EX_TW: begin
        t_nxt = quo_k;
        e_nxt = k_r[0] ? (e_r - quo_k) : (e_r + quo_k);
        k_nxt = k_r + 4'd1;
      end
      ST_EX_OUT: begin
        cov_nxt = (n_r > 5'(EXP_N_MAX)) ? 17'd0 : 17'(rnd >> out_sh);
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_cov_nxt   = cov_r;
          out_sat_nxt   = sat_r;
          sum_nxt       = '0;
          sat_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= KIND_GAUSS;
      sum_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      sum_r       <= sum_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= 64'(mul_a) * 64'(mul_b);
    last_r    <= last_nxt;
    magnz_r   <= magnz_nxt;
    q_r       <= q_nxt;
    acc_r     <= acc_nxt;
    d_r       <= d_nxt;
    s_r       <= s_nxt;
    q3_r      <= q3_nxt;
    r3_r      <= r3_nxt;
    m_r       <= m_nxt;
    em_r      <= em_nxt;
    p_r       <= p_nxt;
    ip_r      <= ip_nxt;
    y_r       <= y_nxt;
    fr_r      <= fr_nxt;
    it_r      <= it_nxt;
    ln_r      <= ln_nxt;
    term_r    <= term_nxt;
    n_r       <= n_nxt;
    g_r       <= g_nxt;
    t_r       <= t_nxt;
    e_r       <= e_nxt;
    k_r       <= k_nxt;
    cov_r     <= cov_nxt;
    out_cov_r <= out_cov_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_covariance    = out_cov_r;
  assign out_sum_saturated = out_sat_r;

endmodule

>>> verif/separable_covariance_kernel_unit_checker.sv
`timescale 1ns / 100ps

module separable_covariance_kernel_unit_checker import sck_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_coord_diff,
  input  logic        [31:0] in_length_scale,
  input  logic               in_last_coord,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic        [16:0] out_covariance,
  input  logic               out_sum_saturated,
  input  logic               cfg_write_en,
  input  logic         [2:0] cfg_kernel_kind,
  output int                 fail_count,
  output int                 pending_count,
  output int                 coord_count,
  output int                 vector_count,
  output int                 sat_count
);

  localparam logic [63:0] ONE30 = 64'd1 << 30;

  typedef struct packed {
    logic [16:0] covariance;
    logic        saturated;
  } kernel_value_t;

  kernel_value_t covar_q[$];
  logic [2:0]    kind_r;
  logic [63:0]   acc_sum;
  logic          acc_sat;

  function automatic logic [63:0] scale_q30(logic [63:0] q, logic [63:0] c);
    logic [63:0] hi, lo;
    hi = (q >> 20) * c;
    lo = (q & 64'hFFFFF) * c;
    return (hi >> 10) + ((((hi & 64'd1023) << 20) + lo) >> 30);
  endfunction

  function automatic logic [63:0] nat_log(logic [63:0] m, int e);
    int p, ip;
    logic [63:0] y, fr, lhi, lfr;
    if (m == 0) return 64'd0;
    p = 63;
    while (m[p] == 1'b0) p--;
    ip = p + e;
    if (ip < 0) return 64'd0;
    y = (p >= 30) ? (m >> (p - 30)) : (m << (30 - p));
    fr = 0;
    for (int i = 0; i < LN_ITERS; i++) begin
      y = (y * y) >> 30;
      fr = fr << 1;
      if (y >= 2 * ONE30) begin
        y = y >> 1;
        fr = fr | 64'd1;
      end
    end
    lhi = 64'(ip) * 64'(L2_Q30);
    lfr = (fr * 64'(L2_Q30)) >> 30;
    return (lhi + lfr) >> (30 - FRAC_BITS);
  endfunction

  function automatic logic [16:0] neg_exp(logic [63:0] s);
    logic [63:0] s30, u, n, g, e, t;
    if (s >= (64'd12 << FRAC_BITS)) return 17'd0;
    s30 = s << (30 - FRAC_BITS);
    u = (s30 * 64'(LOG2E_Q28)) >> 28;
    n = u >> 30;
    g = ((u & (ONE30 - 1)) * 64'(L2_Q30)) >> 30;
    e = ONE30;
    t = ONE30;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      t = ((t * g) >> 30) / 64'(k);
      if (k % 2 == 1) e = e - t;
      else e = e + t;
    end
    if (n > EXP_N_MAX) return 17'd0;
    return 17'((e + (64'd1 << (13 + n))) >> (14 + n));
  endfunction

  task automatic add_term(logic [63:0] t);
    if (t > 64'(SUM_MAX) - acc_sum) begin
      acc_sum = 64'(SUM_MAX);
      acc_sat = 1'b1;
    end else begin
      acc_sum = acc_sum + t;
    end
  endtask

  // advance the kernel sum by one coordinate, queue a value at vector end
  task automatic fold_coordinate(logic [31:0] diff, logic [31:0] scale, logic last);
    logic [63:0] mag, q, d, lnv, ds, sq, base, lin;
    int s;
    kernel_value_t r;
    mag = diff[31] ? ((64'd1 << 32) - 64'(diff)) : 64'(diff);
    if (mag == 0) q = 0;
    else if (scale == 0) q = 64'(SUM_MAX) + 1;
    else q = (mag << FRAC_BITS) / 64'(scale);
    if (kind_r <= KIND_WHITE && q > 64'(SUM_MAX)) begin
      acc_sum = 64'(SUM_MAX);
      acc_sat = 1'b1;
    end else begin
      case (kind_r)
        KIND_GAUSS: begin
          if (q >= (64'd1 << 32)) begin
            acc_sum = 64'(SUM_MAX);
            acc_sat = 1'b1;
          end else add_term((q * q) >> (FRAC_BITS + 1));
        end
        KIND_EXP: add_term(q);
        KIND_M32: begin
          d = scale_q30(q, 64'(S3_Q30));
          lnv = nat_log((64'd1 << FRAC_BITS) + d, -FRAC_BITS);
          add_term(d > lnv ? d - lnv : 64'd0);
        end
        KIND_M52: begin
          d = scale_q30(q, 64'(S5_Q30));
          s = 0;
          while ((d >> s) >= (64'd1 << 32)) s++;
          ds = d >> s;
          sq = (ds * ds) / 64'd3;
          base = ((64'd1 << FRAC_BITS) + d) >> s;
          lin = (FRAC_BITS >= s) ? (base << (FRAC_BITS - s)) : (base >> (s - FRAC_BITS));
          lnv = nat_log(sq + lin, 2 * s - 2 * FRAC_BITS);
          add_term(d > lnv ? d - lnv : 64'd0);
        end
        KIND_WHITE: add_term((mag != 0 && q == 0) ? 64'd1 : q);
        default: ;
      endcase
    end
    if (last) begin
      if (kind_r == KIND_WHITE)
        r.covariance = (acc_sum == 0 && !acc_sat) ? 17'd65536 : 17'd0;
      else
        r.covariance = neg_exp(acc_sum);
      r.saturated = acc_sat;
      covar_q.push_back(r);
      acc_sum = 0;
      acc_sat = 1'b0;
    end
  endtask

  assign pending_count = covar_q.size();

  always @(posedge clk) begin
    kernel_value_t exp_v;
    if (!rst_n) begin
      kind_r <= KIND_GAUSS;
      acc_sum = 0;
      acc_sat = 1'b0;
      covar_q.delete();
      fail_count <= 0;
      coord_count <= 0;
      vector_count <= 0;
      sat_count <= 0;
    end else begin
      if (cfg_write_en) kind_r <= cfg_kernel_kind;
      if (in_valid && !in_stall) begin
        fold_coordinate(in_coord_diff, in_length_scale, in_last_coord);
        coord_count <= coord_count + 1;
      end
      if (out_valid && !out_stall) begin
        vector_count <= vector_count + 1;
        if (out_sum_saturated) sat_count <= sat_count + 1;
        if (covar_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: covariance %0d saturated %0b",
                     out_covariance, out_sum_saturated);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = covar_q.pop_front();
          if (exp_v.covariance !== out_covariance || exp_v.saturated !== out_sum_saturated) begin
            if (fail_count < 10)
              $display("mismatch: covariance exp %0d got %0d, saturated exp %0b got %0b",
                       exp_v.covariance, out_covariance, exp_v.saturated, out_sum_saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/separable_covariance_kernel_unit_tb.sv
`timescale 1ns / 100ps

module separable_covariance_kernel_unit_tb import sck_pkg::*;;

  // generous bound, many times the expected length of the whole run
  localparam int CYCLE_LIMIT = 6000000;
  // cycles a non-closing transaction may still be busy inside the block
  localparam int SETTLE_CYCLES = 1500;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_coord_diff;
  logic        [31:0] in_length_scale;
  logic               in_last_coord;
  logic               out_valid;
  logic               out_stall;
  logic        [16:0] out_covariance;
  logic               out_sum_saturated;
  logic               cfg_write_en;
  logic         [2:0] cfg_kernel_kind;

  int fail_count, pending_count, coord_count, vector_count, sat_count;
  int cycle_count;
  logic quiet;  // no idling on either side while set

  separable_covariance_kernel_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_coord_diff    (in_coord_diff),
    .in_length_scale  (in_length_scale),
    .in_last_coord    (in_last_coord),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_covariance   (out_covariance),
    .out_sum_saturated(out_sum_saturated),
    .cfg_write_en     (cfg_write_en),
    .cfg_kernel_kind  (cfg_kernel_kind)
  );

  separable_covariance_kernel_unit_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_coord_diff    (in_coord_diff),
    .in_length_scale  (in_length_scale),
    .in_last_coord    (in_last_coord),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_covariance   (out_covariance),
    .out_sum_saturated(out_sum_saturated),
    .cfg_write_en     (cfg_write_en),
    .cfg_kernel_kind  (cfg_kernel_kind),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .coord_count      (coord_count),
    .vector_count     (vector_count),
    .sat_count        (sat_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on total run length
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // random result side back-pressure, drawn with a chance of 9 in 100 unless quiet
  always @(posedge clk) begin
    if (!rst_n || quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 9);
  end

  // present one coordinate transaction and hold it until accepted
  task automatic send_coord(logic [31:0] diff, logic [31:0] scale, logic last);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coord_diff <= diff;
    in_length_scale <= scale;
    in_last_coord <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // drain all outstanding results, let a non-closing transaction finish, then reprogram
  task automatic set_kind(logic [2:0] kind);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_kernel_kind <= kind;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // random coordinate: mostly ratios of a few units, some raw 32-bit noise
  task automatic send_random_coord(logic last);
    logic [31:0] scale, diff;
    int unsigned span;
    if ($urandom_range(0, 99) < 12) begin
      diff = $urandom();
      scale = $urandom();
      if (scale == 0) scale = 32'd1;
    end else begin
      scale = $urandom_range(32'h100, 32'h40000);
      span = (scale > 32'h1000000) ? 32'h7fffffff : scale * $urandom_range(1, 6);
      diff = $urandom_range(0, span);
      if ($urandom_range(0, 1)) diff = -diff;
      if ($urandom_range(0, 19) == 0) diff = 0;
    end
    send_coord(diff, scale, last);
  endtask

  task automatic random_vectors(int n_coords);
    int left, len;
    left = n_coords;
    while (left > 0) begin
      len = $urandom_range(1, 4);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) send_random_coord(i == len - 1);
      left -= len;
    end
  endtask

  logic [2:0] kind_plan [10] = '{KIND_EXP, KIND_M32, KIND_M52, KIND_WHITE, KIND_GAUSS,
                                 3'd5, 3'd7, KIND_M52, KIND_M32, KIND_EXP};

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    in_valid = 1'b0;
    in_coord_diff = '0;
    in_length_scale = 32'd1;
    in_last_coord = 1'b0;
    cfg_write_en = 1'b0;
    cfg_kernel_kind = KIND_GAUSS;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: gauss extremes, zero and huge ratios, zero scale
    set_kind(KIND_GAUSS);
    send_coord(32'h0, 32'h1, 1'b1);
    send_coord(32'h7fffffff, 32'h1, 1'b1);
    send_coord(32'h80000000, 32'h1, 1'b1);
    send_coord(32'h00010000, 32'h00010000, 1'b1);
    send_coord(32'hffffffff, 32'hffffffff, 1'b1);
    send_coord(32'h5, 32'h0, 1'b1);
    send_coord(32'h0, 32'h0, 1'b1);
    // exp, then a kind change in the middle of a vector
    set_kind(KIND_EXP);
    send_coord(32'h7fffffff, 32'hffffffff, 1'b1);
    send_coord(-32'sh10000, 32'h10000, 1'b0);
    set_kind(KIND_M32);
    send_coord(32'h20000, 32'h10000, 1'b1);
    send_coord(32'h18000, 32'h8000, 1'b1);
    // matern 5/2: normal, saturating and wide d needing the mantissa shift
    set_kind(KIND_M52);
    send_coord(32'h30000, 32'h10000, 1'b1);
    send_coord(32'h7fffffff, 32'h1, 1'b1);
    send_coord(32'h7fffffff, 32'h100, 1'b1);
    send_coord(32'h1, 32'hffffffff, 1'b1);
    // whitenoise: zero vector, truncated-to-zero ratio, multi-coordinate zero
    set_kind(KIND_WHITE);
    send_coord(32'h0, 32'h5, 1'b1);
    send_coord(32'h1, 32'hffffffff, 1'b1);
    send_coord(32'h0, 32'h7, 1'b0);
    send_coord(32'h0, 32'h7, 1'b1);
    send_coord(32'h10000, 32'h10000, 1'b1);

    // random phases over every kind, one long stretch with no idling
    foreach (kind_plan[i]) begin
      set_kind(kind_plan[i]);
      quiet = (i == 4);
      random_vectors(70);
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d coordinates in %0d vectors over every defined kind and two undefined",
             coord_count, vector_count);
    $display("%0d vectors reported a saturated sum, %0d mismatches", sat_count, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
